FILE: hdl/scp_pkg.sv
// Shared types and constants for the segment closest-points pipeline.
// Used by scp_mul, scp_div and segment_closest_points; no dependencies.
package scp_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int THR_W     = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int DOT_W     = 2 * DIFF_W + 2;
    localparam int WIDE_W    = 2 * DOT_W;
    localparam int MUL_HALF  = DOT_W / 2;
    localparam int QW        = FRAC_BITS + 1;

    localparam logic [QW-1:0]     ONE_FX     = QW'(1) << FRAC_BITS;
    localparam logic [WIDE_W-1:0] HALF_FX    = WIDE_W'(1) << (FRAC_BITS - 1);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(4295);

    localparam int MUL_LAT = 4;
    localparam int DIV_LAT = QW + 2;

    localparam int STG_A = MUL_LAT + 2;
    localparam int STG_B = STG_A + MUL_LAT + 1;
    localparam int STG_C = STG_B + DIV_LAT + MUL_LAT + 1;
    localparam int STG_D = STG_C + DIV_LAT + 1;
    localparam int STG_E = STG_D + MUL_LAT + 1;

    localparam int DOT_A = 0;
    localparam int DOT_E = 1;
    localparam int DOT_B = 2;
    localparam int DOT_C = 3;
    localparam int DOT_F = 4;

    localparam logic [1:0] CASE_BOTH    = 2'd0;
    localparam logic [1:0] CASE_FIRST   = 2'd1;
    localparam logic [1:0] CASE_SECOND  = 2'd2;
    localparam logic [1:0] CASE_GENERAL = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg1_start_x;
        logic signed [COORD_W-1:0] seg1_start_y;
        logic signed [COORD_W-1:0] seg1_start_z;
        logic signed [COORD_W-1:0] seg1_end_x;
        logic signed [COORD_W-1:0] seg1_end_y;
        logic signed [COORD_W-1:0] seg1_end_z;
        logic signed [COORD_W-1:0] seg2_start_x;
        logic signed [COORD_W-1:0] seg2_start_y;
        logic signed [COORD_W-1:0] seg2_start_z;
        logic signed [COORD_W-1:0] seg2_end_x;
        logic signed [COORD_W-1:0] seg2_end_y;
        logic signed [COORD_W-1:0] seg2_end_z;
    } seg_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] near1_x;
        logic signed [COORD_W-1:0] near1_y;
        logic signed [COORD_W-1:0] near1_z;
        logic signed [COORD_W-1:0] near2_x;
        logic signed [COORD_W-1:0] near2_y;
        logic signed [COORD_W-1:0] near2_z;
        logic [1:0]                case_code;
    } seg_res_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [2:0][COORD_W-1:0] p2;
        logic [2:0][DIFF_W-1:0]  d1;
        logic [2:0][DIFF_W-1:0]  d2;
    } geo_t;

    typedef struct packed {
        logic [QW-1:0] s_gen;
        logic [QW-1:0] s_c;
        logic [QW-1:0] s_bc;
        logic [QW-1:0] t_deg;
    } quot_t;

endpackage

FILE: hdl/scp_mul.sv
// Pipelined signed DOT_W x DOT_W multiplier, four register stages.
// Depends on scp_pkg.
module scp_mul
    import scp_pkg::*;
(
    input  logic              clk,
    input  logic [DOT_W-1:0]  a,
    input  logic [DOT_W-1:0]  b,
    output logic [WIDE_W-1:0] p
);

    logic                    neg1_reg, neg2_reg, neg3_reg;
    logic [DOT_W-1:0]        ma_reg, mb_reg;
    logic [2*MUL_HALF-1:0]   hh_reg, hl_reg, lh_reg, ll_reg;
    logic [WIDE_W-1:0]       sum_reg, p_reg;

    always_ff @(posedge clk)
    begin
        neg1_reg <= a[DOT_W-1] ^ b[DOT_W-1];
        ma_reg   <= a[DOT_W-1] ? (~a + 1'b1) : a;
        mb_reg   <= b[DOT_W-1] ? (~b + 1'b1) : b;

        neg2_reg <= neg1_reg;
        hh_reg   <= ma_reg[DOT_W-1:MUL_HALF] * mb_reg[DOT_W-1:MUL_HALF];
        hl_reg   <= ma_reg[DOT_W-1:MUL_HALF] * mb_reg[MUL_HALF-1:0];
        lh_reg   <= ma_reg[MUL_HALF-1:0] * mb_reg[DOT_W-1:MUL_HALF];
        ll_reg   <= ma_reg[MUL_HALF-1:0] * mb_reg[MUL_HALF-1:0];

        neg3_reg <= neg2_reg;
        sum_reg  <= {hh_reg, ll_reg}
                  + {{MUL_HALF{1'b0}}, hl_reg, {MUL_HALF{1'b0}}}
                  + {{MUL_HALF{1'b0}}, lh_reg, {MUL_HALF{1'b0}}};

        p_reg    <= neg3_reg ? (~sum_reg + 1'b1) : sum_reg;
    end

    assign p = p_reg;

endmodule

FILE: hdl/scp_div.sv
// Pipelined saturating divider: num/den clamped to 0..1, rounded half up.
// One restoring step per stage; depends on scp_pkg.
module scp_div
    import scp_pkg::*;
(
    input  logic              clk,
    input  logic [WIDE_W-1:0] num,
    input  logic [WIDE_W-1:0] den,
    output logic [QW-1:0]     quo
);

    logic [WIDE_W-1:0] rem_reg  [0:QW];
    logic [WIDE_W-1:0] den_reg  [0:QW];
    logic [QW-1:0]     q_reg    [0:QW];
    logic              zero_reg [0:QW];
    logic              one_reg  [0:QW];
    logic [WIDE_W-1:0] rem_next [1:QW];
    logic [QW-1:0]     q_next   [1:QW];
    logic [QW-1:0]     quo_reg;

    always_comb
    begin
        logic [WIDE_W-1:0] sh;
        logic              ge;
        for (int i = 1; i <= QW; i++)
        begin
            sh          = {rem_reg[i-1][WIDE_W-2:0], 1'b0};
            ge          = sh >= den_reg[i-1];
            rem_next[i] = ge ? (sh - den_reg[i-1]) : sh;
            q_next[i]   = {q_reg[i-1][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num;
        den_reg[0]  <= den;
        q_reg[0]    <= '0;
        zero_reg[0] <= ($signed(den) <= 0) || ($signed(num) <= 0);
        one_reg[0]  <= $signed(num) >= $signed(den);
        for (int i = 1; i <= QW; i++)
        begin
            rem_reg[i]  <= rem_next[i];
            den_reg[i]  <= den_reg[i-1];
            q_reg[i]    <= q_next[i];
            zero_reg[i] <= zero_reg[i-1];
            one_reg[i]  <= one_reg[i-1];
        end
        if (zero_reg[QW])
            quo_reg <= '0;
        else if (one_reg[QW])
            quo_reg <= ONE_FX;
        else
            quo_reg <= QW'(({1'b0, q_reg[QW]} + 1'b1) >> 1);
    end

    assign quo = quo_reg;

endmodule

FILE: hdl/segment_closest_points.sv
// Closest points between two 3D segments, signed Q16.16, fully pipelined.
// Throughput: one request per cycle; busy stays low, set by the pipelined
// multipliers (4 stages) and the 19-stage restoring dividers.
// Reset clears the valid pipeline and loads the threshold with 4295.
// The receiver cannot stall; each result shows for exactly one cycle.
module segment_closest_points
    import scp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  seg_req_t         req,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata,
    output logic             res_valid,
    output seg_res_t         res
);

    localparam int GEO_LEN  = STG_D - 1;
    localparam int FE_LEN   = DIV_LAT + MUL_LAT;
    localparam int QT_LEN   = STG_C - STG_B;
    localparam int CODE_LEN = STG_D + MUL_LAT - STG_B;
    localparam int CODE_SEL = STG_D - STG_B - 2;

    function automatic logic [DOT_W-1:0] dext(input logic [DIFF_W-1:0] x);
        return {{(DOT_W-DIFF_W){x[DIFF_W-1]}}, x};
    endfunction

    function automatic logic [WIDE_W-1:0] wext(input logic [DOT_W-1:0] x);
        return {{(WIDE_W-DOT_W){x[DOT_W-1]}}, x};
    endfunction

    logic                      valid_reg [STG_E];
    logic [THR_W-1:0]          thr_reg;

    logic [2:0][COORD_W-1:0]   in_p1, in_q1, in_p2, in_q2;
    geo_t                      geo_next, geo_reg;
    logic [2:0][DIFF_W-1:0]    r_next, r_reg;
    geo_t                      geo_pipe_reg [GEO_LEN];
    geo_t                      geo_sd;

    logic [4:0][2:0][DIFF_W-1:0] dop_a, dop_b;
    logic [WIDE_W-1:0]         dprod [5][3];
    logic [4:0][DOT_W-1:0]     dot_reg;
    logic [4:0][DOT_W-1:0]     dot_pipe_reg [MUL_LAT];
    logic [4:0][DOT_W-1:0]     dot_d;
    logic [WIDE_W-1:0]         ae_prod, bb_prod, bf_prod, ce_prod;

    logic [WIDE_W-1:0]         num_reg, den_reg, negc_reg, bmc_reg;
    logic [WIDE_W-1:0]         aw_reg, ew_reg, fw_reg;
    logic [DOT_W-1:0]          b_reg;
    logic [1:0]                code_next, code_reg;
    logic                      deg1, deg2;

    quot_t                     quot_div;
    quot_t                     qt_pipe_reg [QT_LEN];
    quot_t                     qt_sel;
    logic [DOT_W-1:0]          b_pipe_reg [DIV_LAT];
    logic [WIDE_W-1:0]         f_pipe_reg [FE_LEN];
    logic [WIDE_W-1:0]         e_pipe_reg [FE_LEN];
    logic [1:0]                code_pipe_reg [CODE_LEN];
    logic [WIDE_W-1:0]         bs_prod;
    logic [WIDE_W-1:0]         nt_reg, dt_reg;
    logic [QW-1:0]             t_div;
    logic                      ntneg_pipe_reg [DIV_LAT];
    logic                      ntgt_pipe_reg  [DIV_LAT];

    logic [QW-1:0]             s_next, t_next, s_reg, t_reg;
    logic [WIDE_W-1:0]         aprod [2][3];
    logic [1:0][2:0][COORD_W-1:0] p_pipe_reg [MUL_LAT];
    seg_res_t                  res_next, res_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            for (int i = 0; i < STG_E; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            valid_reg[0] <= start && !busy;
            for (int i = 1; i < STG_E; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // stage 1: differences
    always_comb
    begin
        in_p1 = {req.seg1_start_z, req.seg1_start_y, req.seg1_start_x};
        in_q1 = {req.seg1_end_z, req.seg1_end_y, req.seg1_end_x};
        in_p2 = {req.seg2_start_z, req.seg2_start_y, req.seg2_start_x};
        in_q2 = {req.seg2_end_z, req.seg2_end_y, req.seg2_end_x};
        geo_next.p1 = in_p1;
        geo_next.p2 = in_p2;
        for (int k = 0; k < 3; k++)
        begin
            geo_next.d1[k] = {in_q1[k][COORD_W-1], in_q1[k]}
                           - {in_p1[k][COORD_W-1], in_p1[k]};
            geo_next.d2[k] = {in_q2[k][COORD_W-1], in_q2[k]}
                           - {in_p2[k][COORD_W-1], in_p2[k]};
            r_next[k]      = {in_p1[k][COORD_W-1], in_p1[k]}
                           - {in_p2[k][COORD_W-1], in_p2[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        geo_reg <= geo_next;
        r_reg   <= r_next;
        geo_pipe_reg[0] <= geo_reg;
        for (int i = 1; i < GEO_LEN; i++)
            geo_pipe_reg[i] <= geo_pipe_reg[i-1];
    end

    assign geo_sd = geo_pipe_reg[GEO_LEN-1];

    // dot products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dop_a[DOT_A][k] = geo_reg.d1[k];
            dop_b[DOT_A][k] = geo_reg.d1[k];
            dop_a[DOT_E][k] = geo_reg.d2[k];
            dop_b[DOT_E][k] = geo_reg.d2[k];
            dop_a[DOT_B][k] = geo_reg.d1[k];
            dop_b[DOT_B][k] = geo_reg.d2[k];
            dop_a[DOT_C][k] = geo_reg.d1[k];
            dop_b[DOT_C][k] = r_reg[k];
            dop_a[DOT_F][k] = geo_reg.d2[k];
            dop_b[DOT_F][k] = r_reg[k];
        end
    end

    for (genvar j = 0; j < 5; j++)
    begin : g_dot
        for (genvar k = 0; k < 3; k++)
        begin : g_term
            scp_mul u_mul (
                .clk (clk),
                .a   (dext(dop_a[j][k])),
                .b   (dext(dop_b[j][k])),
                .p   (dprod[j][k])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 5; j++)
            dot_reg[j] <= dprod[j][0][DOT_W-1:0] + dprod[j][1][DOT_W-1:0]
                        + dprod[j][2][DOT_W-1:0];
        dot_pipe_reg[0] <= dot_reg;
        for (int i = 1; i < MUL_LAT; i++)
            dot_pipe_reg[i] <= dot_pipe_reg[i-1];
    end

    assign dot_d = dot_pipe_reg[MUL_LAT-1];

    scp_mul u_mul_ae (.clk(clk), .a(dot_reg[DOT_A]), .b(dot_reg[DOT_E]), .p(ae_prod));
    scp_mul u_mul_bb (.clk(clk), .a(dot_reg[DOT_B]), .b(dot_reg[DOT_B]), .p(bb_prod));
    scp_mul u_mul_bf (.clk(clk), .a(dot_reg[DOT_B]), .b(dot_reg[DOT_F]), .p(bf_prod));
    scp_mul u_mul_ce (.clk(clk), .a(dot_reg[DOT_C]), .b(dot_reg[DOT_E]), .p(ce_prod));

    // degenerate check and division operands
    always_comb
    begin
        deg1 = dot_d[DOT_A] <= {{(DOT_W-THR_W){1'b0}}, thr_reg};
        deg2 = dot_d[DOT_E] <= {{(DOT_W-THR_W){1'b0}}, thr_reg};
        if (deg1 && deg2)
            code_next = CASE_BOTH;
        else if (deg1)
            code_next = CASE_FIRST;
        else if (deg2)
            code_next = CASE_SECOND;
        else
            code_next = CASE_GENERAL;
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= bf_prod - ce_prod;
        den_reg  <= ae_prod - bb_prod;
        negc_reg <= '0 - wext(dot_d[DOT_C]);
        bmc_reg  <= wext(dot_d[DOT_B]) - wext(dot_d[DOT_C]);
        aw_reg   <= wext(dot_d[DOT_A]);
        ew_reg   <= wext(dot_d[DOT_E]);
        fw_reg   <= wext(dot_d[DOT_F]);
        b_reg    <= dot_d[DOT_B];
        code_reg <= code_next;
    end

    scp_div u_div_s   (.clk(clk), .num(num_reg),  .den(den_reg), .quo(quot_div.s_gen));
    scp_div u_div_sc  (.clk(clk), .num(negc_reg), .den(aw_reg),  .quo(quot_div.s_c));
    scp_div u_div_sbc (.clk(clk), .num(bmc_reg),  .den(aw_reg),  .quo(quot_div.s_bc));
    scp_div u_div_td  (.clk(clk), .num(fw_reg),   .den(ew_reg),  .quo(quot_div.t_deg));

    always_ff @(posedge clk)
    begin
        b_pipe_reg[0] <= b_reg;
        for (int i = 1; i < DIV_LAT; i++)
            b_pipe_reg[i] <= b_pipe_reg[i-1];
        f_pipe_reg[0] <= fw_reg;
        e_pipe_reg[0] <= ew_reg;
        for (int i = 1; i < FE_LEN; i++)
        begin
            f_pipe_reg[i] <= f_pipe_reg[i-1];
            e_pipe_reg[i] <= e_pipe_reg[i-1];
        end
        code_pipe_reg[0] <= code_reg;
        for (int i = 1; i < CODE_LEN; i++)
            code_pipe_reg[i] <= code_pipe_reg[i-1];
        qt_pipe_reg[0] <= quot_div;
        for (int i = 1; i < QT_LEN; i++)
            qt_pipe_reg[i] <= qt_pipe_reg[i-1];
    end

    assign qt_sel = qt_pipe_reg[QT_LEN-1];

    scp_mul u_mul_bs (
        .clk (clk),
        .a   (b_pipe_reg[DIV_LAT-1]),
        .b   ({{(DOT_W-QW){1'b0}}, quot_div.s_gen}),
        .p   (bs_prod)
    );

    // t numerator with the quantized s
    always_ff @(posedge clk)
    begin
        nt_reg <= bs_prod
                + {f_pipe_reg[FE_LEN-1][WIDE_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        dt_reg <= {e_pipe_reg[FE_LEN-1][WIDE_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        ntneg_pipe_reg[0] <= nt_reg[WIDE_W-1];
        ntgt_pipe_reg[0]  <= $signed(nt_reg) > $signed(dt_reg);
        for (int i = 1; i < DIV_LAT; i++)
        begin
            ntneg_pipe_reg[i] <= ntneg_pipe_reg[i-1];
            ntgt_pipe_reg[i]  <= ntgt_pipe_reg[i-1];
        end
    end

    scp_div u_div_t (.clk(clk), .num(nt_reg), .den(dt_reg), .quo(t_div));

    // pick s and t
    always_comb
    begin
        case (code_pipe_reg[CODE_SEL])
            CASE_BOTH:
            begin
                s_next = '0;
                t_next = '0;
            end
            CASE_FIRST:
            begin
                s_next = '0;
                t_next = qt_sel.t_deg;
            end
            CASE_SECOND:
            begin
                s_next = qt_sel.s_c;
                t_next = '0;
            end
            default:
            begin
                if (ntneg_pipe_reg[DIV_LAT-1])
                begin
                    s_next = qt_sel.s_c;
                    t_next = '0;
                end
                else if (ntgt_pipe_reg[DIV_LAT-1])
                begin
                    s_next = qt_sel.s_bc;
                    t_next = ONE_FX;
                end
                else
                begin
                    s_next = qt_sel.s_gen;
                    t_next = t_div;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        t_reg <= t_next;
        p_pipe_reg[0] <= {geo_sd.p2, geo_sd.p1};
        for (int i = 1; i < MUL_LAT; i++)
            p_pipe_reg[i] <= p_pipe_reg[i-1];
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_along
        scp_mul u_mul_s (
            .clk (clk),
            .a   (dext(geo_sd.d1[k])),
            .b   ({{(DOT_W-QW){1'b0}}, s_reg}),
            .p   (aprod[0][k])
        );
        scp_mul u_mul_t (
            .clk (clk),
            .a   (dext(geo_sd.d2[k])),
            .b   ({{(DOT_W-QW){1'b0}}, t_reg}),
            .p   (aprod[1][k])
        );
    end

    // points along the segments
    always_comb
    begin
        logic [WIDE_W-1:0]             mh;
        logic [1:0][2:0][COORD_W-1:0]  pt;
        for (int g = 0; g < 2; g++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mh        = aprod[g][k] + HALF_FX;
                pt[g][k]  = p_pipe_reg[MUL_LAT-1][g][k]
                          + mh[FRAC_BITS+COORD_W-1:FRAC_BITS];
            end
        end
        res_next.near1_x   = pt[0][0];
        res_next.near1_y   = pt[0][1];
        res_next.near1_z   = pt[0][2];
        res_next.near2_x   = pt[1][0];
        res_next.near2_y   = pt[1][1];
        res_next.near2_z   = pt[1][2];
        res_next.case_code = code_pipe_reg[CODE_LEN-1];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = valid_reg[STG_E-1];

    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STG_D-1] |-> (s_reg <= ONE_FX) && (t_reg <= ONE_FX))
        else $error("segment parameter above one");

    a_both_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STG_D-1] && (code_pipe_reg[STG_D-STG_B-1] == CASE_BOTH)
        |-> (s_reg == '0) && (t_reg == '0))
        else $error("nonzero parameter for two degenerate segments");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(STG_E) res_valid)
        else $error("request result missing at fixed latency");

endmodule
